// ===== rtl/core/qrs_pkg.sv =====
package qrs_pkg;

  // Status codes of a result word.
  localparam logic [1:0] ST_NONQUAD = 2'd0;
  localparam logic [1:0] ST_NOROOT  = 2'd1;
  localparam logic [1:0] ST_DOUBLE  = 2'd2;
  localparam logic [1:0] ST_TWO     = 2'd3;

  // Result word layout: status, root_plus, root_minus, padded to bytes.
  localparam int ROOT_W = 32;
  localparam int OUT_W  = 72;
  localparam int SAT_W  = 64;

  // Sign and clamp an unsigned quotient magnitude into the signed 32-bit range.
  function automatic logic [ROOT_W-1:0] sat_root(input logic [SAT_W-1:0] mag,
                                                 input logic neg);
    logic [ROOT_W-1:0] res;
    if (neg) begin
      if (mag > SAT_W'(64'h8000_0000)) res = 32'h8000_0000;
      else res = -mag[ROOT_W-1:0];
    end else begin
      if (mag > SAT_W'(64'h7fff_ffff)) res = 32'h7fff_ffff;
      else res = mag[ROOT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/qrs_sqrt_cell.sv =====
module qrs_sqrt_cell
  import qrs_pkg::*;
#(
  parameter int RW     = 17,
  parameter int SIDE_W = 34
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*RW-1:0]     x_in,
  input  logic [RW+2:0]       rem_in,
  input  logic [RW-1:0]       root_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic [2*RW-1:0]     x_out,
  output logic [RW+2:0]       rem_out,
  output logic [RW-1:0]       root_out,
  output logic [SIDE_W-1:0]   side_out
);

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          ge;

  // One result bit: bring down two radicand bits and try 4*root+1.
  always_comb begin
    rem_sh = {rem_in[RW:0], x_in[2*RW-1 -: 2]};
    trial  = {1'b0, root_in, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= {x_in[2*RW-3:0], 2'b00};
      rem_out  <= ge ? (rem_sh - trial) : rem_sh;
      root_out <= {root_in[RW-2:0], ge};
      side_out <= side_in;
    end
  end

endmodule

// ===== rtl/core/qrs_div_cell.sv =====
module qrs_div_cell
  import qrs_pkg::*;
#(
  parameter int NW     = 32,
  parameter int DVW    = 17,
  parameter int SIDE_W = 4
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [1:0][NW-1:0]    n_in,
  input  logic [1:0][DVW-1:0]   rem_in,
  input  logic [DVW-1:0]        d_in,
  input  logic [SIDE_W-1:0]     side_in,
  output logic [1:0][NW-1:0]    n_out,
  output logic [1:0][DVW-1:0]   rem_out,
  output logic [DVW-1:0]        d_out,
  output logic [SIDE_W-1:0]     side_out
);

  logic [1:0][DVW:0]    rem_sh;
  logic [1:0]           ge;
  logic [1:0][DVW-1:0]  rem_nx;

  // One quotient bit for each of the two lanes, sharing the divisor.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {rem_in[i], n_in[i][NW-1]};
      ge[i]     = (rem_sh[i] >= {1'b0, d_in});
      rem_nx[i] = ge[i] ? DVW'(rem_sh[i] - {1'b0, d_in}) : rem_sh[i][DVW-1:0];
    end
  end

  // The numerator shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        n_out[i]   <= {n_in[i][NW-2:0], ge[i]};
        rem_out[i] <= rem_nx[i];
      end
      d_out    <= d_in;
      side_out <= side_in;
    end
  end

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// Channel   Direction  Fields (lowest bit first)
// s_*       in         coef_a, coef_b, coef_c (COEF_WIDTH each), zero pad to bytes
// m_*       out        status[1:0], root_plus[33:2], root_minus[65:34], zero pad
//
// One word is accepted per cycle while the pipeline is not held. Each word
// passes the product register, the discriminant register, the chain of square
// root cells (one root bit each), the numerator register and the chain of divide
// cells (one quotient bit each). Reset clears only the valid flags.
// The whole pipeline holds while the output register is full and not taken.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // coef_a, coef_b, coef_c from bit 0 up, then zero pad
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // status, root_plus, root_minus from bit 0 up, then zero pad
  output logic [OUT_W-1:0]                       m_tdata
);

  localparam int CW     = COEF_WIDTH;
  localparam int RW     = CW + 1;
  localparam int XW     = 2 * RW;
  localparam int NUMW   = CW + 3;
  localparam int NW     = CW + 2 + FRAC_BITS;
  localparam int DVW    = CW + 1;
  localparam int SSW    = 2 + 2 * CW;
  localparam int DSW    = 4;
  localparam int L      = RW + NW + 3;

  logic          en;
  logic [L-1:0]  vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input stage: the two products.
  logic signed [CW-1:0]   a_in, b_in, c_in;
  logic signed [CW-1:0]   a0, b0;
  logic signed [2*CW-1:0] bb0, ac0;

  assign a_in = s_tdata[CW-1:0];
  assign b_in = s_tdata[2*CW-1:CW];
  assign c_in = s_tdata[3*CW-1:2*CW];

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= a_in;
      b0  <= b_in;
      bb0 <= b_in * b_in;
      ac0 <= a_in * c_in;
    end
  end

  // Discriminant and classification.
  logic signed [XW-1:0] dlt;
  logic [1:0]           st1_next;
  logic [1:0]           st1;
  logic [XW-1:0]        x1;
  logic signed [CW-1:0] a1, b1;

  always_comb begin
    dlt = XW'(bb0) - (XW'(ac0) <<< 2);
    if (a0 == '0) st1_next = ST_NONQUAD;
    else if (dlt < 0) st1_next = ST_NOROOT;
    else if (dlt == '0) st1_next = ST_DOUBLE;
    else st1_next = ST_TWO;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= st1_next;
      x1  <= (dlt < 0) ? '0 : XW'(dlt);
      a1  <= a0;
      b1  <= b0;
    end
  end

  // Square root chain, one root bit per cell.
  logic [XW-1:0]   x_w    [RW+1];
  logic [RW+2:0]   rem_w  [RW+1];
  logic [RW-1:0]   root_w [RW+1];
  logic [SSW-1:0]  sside_w[RW+1];

  assign x_w[0]     = x1;
  assign rem_w[0]   = '0;
  assign root_w[0]  = '0;
  assign sside_w[0] = {st1, a1, b1};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.RW(RW), .SIDE_W(SSW)) u_cell (
      .clk      (clk),
      .en       (en),
      .x_in     (x_w[k]),
      .rem_in   (rem_w[k]),
      .root_in  (root_w[k]),
      .side_in  (sside_w[k]),
      .x_out    (x_w[k+1]),
      .rem_out  (rem_w[k+1]),
      .root_out (root_w[k+1]),
      .side_out (sside_w[k+1])
    );
  end

  // Numerators, divisor magnitude and result signs.
  logic [1:0]             st_s;
  logic signed [CW-1:0]   a_s, b_s;
  logic signed [NUMW-1:0] bn, rs, np, nm;
  logic [CW+1:0]          magp, magm;
  logic signed [CW:0]     ae, am;

  assign {st_s, a_s, b_s} = sside_w[RW];

  always_comb begin
    bn   = -NUMW'(b_s);
    rs   = $signed({2'b00, root_w[RW]});
    np   = bn + rs;
    nm   = bn - rs;
    magp = (np < 0) ? (CW+2)'(-np) : (CW+2)'(np);
    magm = (nm < 0) ? (CW+2)'(-nm) : (CW+2)'(nm);
    ae   = (CW+1)'(a_s);
    am   = (ae < 0) ? -ae : ae;
  end

  logic [1:0][NW-1:0]  n_w    [NW+1];
  logic [1:0][DVW-1:0] drem_w [NW+1];
  logic [DVW-1:0]      d_w    [NW+1];
  logic [DSW-1:0]      dside_w[NW+1];
  logic [1:0][NW-1:0]  n2;
  logic [DVW-1:0]      d2;
  logic [DSW-1:0]      side2;

  always_ff @(posedge clk) begin
    if (en) begin
      n2[0] <= NW'(magp) << FRAC_BITS;
      n2[1] <= NW'(magm) << FRAC_BITS;
      d2    <= {am[CW-1:0], 1'b0};
      side2 <= {st_s, np[NUMW-1] ^ a_s[CW-1], nm[NUMW-1] ^ a_s[CW-1]};
    end
  end

  assign n_w[0]     = n2;
  assign drem_w[0]  = '0;
  assign d_w[0]     = d2;
  assign dside_w[0] = side2;

  // Divide chain, one quotient bit per cell for both roots.
  for (genvar k = 0; k < NW; k++) begin : g_div
    qrs_div_cell #(.NW(NW), .DVW(DVW), .SIDE_W(DSW)) u_cell (
      .clk      (clk),
      .en       (en),
      .n_in     (n_w[k]),
      .rem_in   (drem_w[k]),
      .d_in     (d_w[k]),
      .side_in  (dside_w[k]),
      .n_out    (n_w[k+1]),
      .rem_out  (drem_w[k+1]),
      .d_out    (d_w[k+1]),
      .side_out (dside_w[k+1])
    );
  end

  // Output register: sign, clamp, and zero roots when there are none.
  logic [1:0]        st_o;
  logic              negp_o, negm_o;
  logic [ROOT_W-1:0] rp, rm;
  logic [1:0]        status;
  logic [ROOT_W-1:0] root_plus, root_minus;

  assign {st_o, negp_o, negm_o} = dside_w[NW];

  always_comb begin
    rp = sat_root(SAT_W'(n_w[NW][0]), negp_o);
    rm = sat_root(SAT_W'(n_w[NW][1]), negm_o);
    if (st_o == ST_NONQUAD || st_o == ST_NOROOT) begin
      rp = '0;
      rm = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status     <= st_o;
      root_plus  <= rp;
      root_minus <= rm;
    end
  end

  // Valid flags follow the words through every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[L-2:0], s_tvalid};
      m_tvalid <= vld[L-1];
    end
  end

  assign m_tdata = {(OUT_W - 2 - 2*ROOT_W)'(0), root_minus, root_plus, status};

  // Cases without roots never show a nonzero root.
  a_noroot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_NONQUAD || status == ST_NOROOT)
      |-> (root_plus == '0 && root_minus == '0))
    else $error("root nonzero without real roots");

  // A double root gives the same value in both lanes.
  a_double_equal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == ST_DOUBLE |-> root_plus == root_minus)
    else $error("double root lanes differ");

  // A held pipeline keeps its valid flags.
  a_hold_vld: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid flags moved during a stall");

endmodule
